### rtl/icpt_pkg.sv
// ----------------------------------------------------------------------------
// icpt_pkg
// Shared types, constants and tables for the integral-criterion PI tuner.
// ----------------------------------------------------------------------------
package icpt_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int KP_SHIFT_OFS  = 2 * FRAC_BITS - 46;
  localparam int TI_SHIFT_OFS  = 46;

  localparam int LOG_LAT = 19;
  localparam int EXP_LAT = 17;
  localparam int DIV_LAT = 36;

  localparam int NUM_W = 49;
  localparam int SH_W  = 10;
  localparam int Q_W   = 32;

  typedef enum logic [1:0] {
    CRIT_IAE  = 2'd0,
    CRIT_ITAE = 2'd1,
    CRIT_ISE  = 2'd2
  } crit_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_IN   = 2'd1,
    ST_ZERO_DEAD = 2'd2
  } status_e;

  typedef enum logic {
    REG_CRIT = 1'b0,
    REG_KIND = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [17:0] a;
    logic signed [17:0] b;
    logic signed [17:0] c;
    logic signed [17:0] d;
  } coef_t;

  typedef struct packed {
    status_e     status;
    logic        neg;
    logic [31:0] cap;
    logic [32:0] kmag;
    logic [31:0] tau;
    coef_t       coef;
  } side_in_t;

  typedef struct packed {
    status_e     status;
    logic        neg;
    logic [31:0] cap;
  } side_div_t;

  typedef struct packed {
    status_e     status;
    logic        neg;
    logic [31:0] cap;
    logic [31:0] kp;
    logic [31:0] ti;
    logic        sat;
  } side_ki_t;

  typedef struct packed {
    logic        saturated;
    logic [1:0]  result_status;
    logic [31:0] integral_gain;
    logic [31:0] integral_time;
    logic [31:0] prop_gain;
  } result_t;

  typedef logic [15:0][30:0] root_tab_t;

  function automatic coef_t coef_lookup(input logic kind, input logic [1:0] crit);
    coef_t c;
    if (!kind) begin
      case (crit)
        CRIT_IAE:  c = '{18'sd49676, 18'sd56426, 18'sd66847, -18'sd21168};
        CRIT_ITAE: c = '{18'sd38404, 18'sd60031, 18'sd67502, -18'sd10813};
        default:   c = '{18'sd68682, 18'sd58786, 18'sd78316, -18'sd24117};
      endcase
    end else begin
      case (crit)
        CRIT_IAE:  c = '{18'sd64487, 18'sd64618, 18'sd39846, 18'sd46334};
        CRIT_ITAE: c = '{18'sd88932, 18'sd62063, 18'sd55181, 18'sd48366};
        default:   c = '{18'sd97976, 18'sd61932, 18'sd72155, 18'sd50528};
      endcase
    end
    return c;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rv;
    logic [63:0] res;
    logic [63:0] b;
    rv  = v;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rv >= res + b) begin
        rv  = rv - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // chained Q30 roots: entry k is 2^(2^(k-16)) as the truncating chain gives it
  function automatic root_tab_t root_table();
    root_tab_t   t;
    logic [63:0] r;
    r = 64'd1 << 31;
    for (int k = 15; k >= 0; k--) begin
      r    = isqrt64(r << 30);
      t[k] = r[30:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOT_Q30 = root_table();

endpackage

### rtl/icpt_log2.sv
// ----------------------------------------------------------------------------
// icpt_log2
// Two-lane log2 pipeline, Q16 result, one squaring step per stage; outputs
// log2(tau) - log2(dead).
// ----------------------------------------------------------------------------
module icpt_log2 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [31:0]        tau_i,
  input  logic [31:0]        dead_i,
  output logic               valid_o,
  output logic signed [21:0] lg_o
);
  import icpt_pkg::*;

  function automatic logic [4:0] msb32(input logic [31:0] x);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) p = 5'(i);
    end
    return p;
  endfunction

  logic [LOG_LAT-1:0] v_q;
  logic [31:0]        x_q  [2];
  logic [4:0]         p_q  [18][2];
  logic [30:0]        m_q  [17][2];
  logic [15:0]        fr_q [17][2];
  logic signed [21:0] lg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[LOG_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= tau_i;
      x_q[1]    <= dead_i;
      p_q[0][0] <= msb32(tau_i);
      p_q[0][1] <= msb32(dead_i);
    end
  end

  logic [61:0] norm [2];
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      norm[l] = {x_q[l], 30'b0} >> p_q[0][l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        m_q[0][l]  <= norm[l][30:0];
        fr_q[0][l] <= '0;
        p_q[1][l]  <= p_q[0][l];
      end
    end
  end

  for (genvar j = 0; j < 16; j++) begin : g_sq
    logic [61:0] prod [2];
    logic [31:0] t    [2];
    logic [15:0] fr_d [2];
    logic [30:0] m_d  [2];
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        prod[l] = {31'b0, m_q[j][l]} * {31'b0, m_q[j][l]};
        t[l]    = prod[l][61:30];
        fr_d[l] = fr_q[j][l];
        fr_d[l][15-j] = t[l][31];
        m_d[l]  = t[l][31] ? t[l][31:1] : t[l][30:0];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < 2; l++) begin
          m_q[j+1][l]  <= m_d[l];
          fr_q[j+1][l] <= fr_d[l];
          // shift position rides along with the mantissa
          p_q[j+2][l]  <= p_q[j+1][l];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lg_q <= $signed({1'b0, p_q[17][0], fr_q[16][0]})
            - $signed({1'b0, p_q[17][1], fr_q[16][1]});
    end
  end

  assign valid_o = v_q[LOG_LAT-1];
  assign lg_o    = lg_q;

endmodule

### rtl/icpt_exp2.sv
// ----------------------------------------------------------------------------
// icpt_exp2
// Two-lane power pipeline: 2^(B*lg) and 2^(-D*lg) as Q30 mantissa plus
// integer exponent, one fraction bit per stage.
// ----------------------------------------------------------------------------
module icpt_exp2 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [21:0] lg_i,
  input  logic signed [17:0] coef_b_i,
  input  logic signed [17:0] coef_d_i,
  output logic               valid_o,
  output logic [30:0]        mant_kp_o,
  output logic signed [8:0]  exp_kp_o,
  output logic [30:0]        mant_ti_o,
  output logic signed [8:0]  exp_ti_o
);
  import icpt_pkg::*;

  logic [EXP_LAT-1:0] v_q;
  logic signed [40:0] prod_q [2];
  logic [30:0]        acc_q  [17][2];
  logic [15:0]        f_q    [17][2];
  logic signed [8:0]  n_q    [17][2];

  logic signed [22:0] neg_lg;
  assign neg_lg = -$signed({lg_i[21], lg_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[EXP_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q[0] <= 41'(coef_b_i) * 41'(lg_i);
      prod_q[1] <= 41'(coef_d_i) * 41'(neg_lg);
    end
  end

  // floor split: exponent = prod >>> 32, fraction = prod[31:16]
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      acc_q[0][l] = 31'h4000_0000;
      f_q[0][l]   = prod_q[l][31:16];
      n_q[0][l]   = prod_q[l][40:32];
    end
  end

  for (genvar i = 0; i < 16; i++) begin : g_rt
    logic [61:0] pr [2];
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        pr[l] = {31'b0, acc_q[i][l]} * {31'b0, ROOT_Q30[15-i]};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < 2; l++) begin
          acc_q[i+1][l] <= f_q[i][l][15-i] ? pr[l][60:30] : acc_q[i][l];
          f_q[i+1][l]   <= f_q[i][l];
          n_q[i+1][l]   <= n_q[i][l];
        end
      end
    end
  end

  assign valid_o   = v_q[EXP_LAT-1];
  assign mant_kp_o = acc_q[16][0];
  assign exp_kp_o  = n_q[16][0];
  assign mant_ti_o = acc_q[16][1];
  assign exp_ti_o  = n_q[16][1];

endmodule

### rtl/icpt_div.sv
// ----------------------------------------------------------------------------
// icpt_div
// Pipelined scaled divider: min(floor(num * 2^shift / den), cap), one
// quotient bit per stage, with saturation flag.
// ----------------------------------------------------------------------------
module icpt_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [icpt_pkg::NUM_W-1:0]     num_i,
  input  logic signed [icpt_pkg::SH_W-1:0] shift_i,
  input  logic [icpt_pkg::NUM_W-1:0]     den_i,
  input  logic [icpt_pkg::Q_W-1:0]       cap_i,
  output logic                           valid_o,
  output logic [icpt_pkg::Q_W-1:0]       quo_o,
  output logic                           sat_o
);
  import icpt_pkg::*;

  localparam int WIDE_W = 130;
  localparam int LOW_W  = Q_W + 1;
  localparam int MAX_SH = WIDE_W - NUM_W;

  logic [DIV_LAT-1:0] v_q;

  logic [WIDE_W-1:0]  a_wide_q;
  logic               a_big_q;
  logic [NUM_W-1:0]   a_den_q;
  logic [Q_W-1:0]     a_cap_q;

  logic [NUM_W-1:0]   rem_q [LOW_W+1];
  logic [LOW_W-1:0]   low_q [LOW_W+1];
  logic [LOW_W-1:0]   quo_q [LOW_W+1];
  logic [NUM_W-1:0]   den_q [LOW_W+1];
  logic [Q_W-1:0]     cap_q [LOW_W+1];
  logic               ovf_q [LOW_W+1];

  logic [Q_W-1:0]     res_q;
  logic               sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DIV_LAT-2:0], valid_i};
    end
  end

  logic [WIDE_W-1:0] wide_d;
  logic              big_d;
  logic [SH_W-1:0]   amt;
  always_comb begin
    amt = SH_W'(-shift_i);
    if (!shift_i[SH_W-1]) begin
      big_d  = (shift_i >= SH_W'(MAX_SH)) && (num_i != '0);
      wide_d = {{MAX_SH{1'b0}}, num_i} << shift_i[6:0];
    end else begin
      big_d  = 1'b0;
      wide_d = (amt >= SH_W'(NUM_W)) ? '0 : {{MAX_SH{1'b0}}, num_i >> amt[5:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_wide_q <= wide_d;
      a_big_q  <= big_d;
      a_den_q  <= den_i;
      a_cap_q  <= cap_i;
    end
  end

  // high part must stay below den, else the quotient cannot fit
  logic [WIDE_W-LOW_W-1:0] hi;
  logic                    ovf_d;
  assign hi    = a_wide_q[WIDE_W-1:LOW_W];
  assign ovf_d = a_big_q || (|hi[WIDE_W-LOW_W-1:NUM_W]) || (hi[NUM_W-1:0] >= a_den_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= hi[NUM_W-1:0];
      low_q[0] <= a_wide_q[LOW_W-1:0];
      quo_q[0] <= '0;
      den_q[0] <= a_den_q;
      cap_q[0] <= a_cap_q;
      ovf_q[0] <= ovf_d;
    end
  end

  for (genvar j = 0; j < LOW_W; j++) begin : g_step
    logic [NUM_W:0] r2;
    logic [NUM_W:0] df;
    logic           ge;
    always_comb begin
      r2 = {rem_q[j], low_q[j][LOW_W-1-j]};
      df = r2 - {1'b0, den_q[j]};
      ge = r2 >= {1'b0, den_q[j]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= ge ? df[NUM_W-1:0] : r2[NUM_W-1:0];
        low_q[j+1] <= low_q[j];
        quo_q[j+1] <= {quo_q[j][LOW_W-2:0], ge};
        den_q[j+1] <= den_q[j];
        cap_q[j+1] <= cap_q[j];
        ovf_q[j+1] <= ovf_q[j];
      end
    end
  end

  logic clip;
  assign clip = ovf_q[LOW_W] || (quo_q[LOW_W] > {1'b0, cap_q[LOW_W]});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= clip ? cap_q[LOW_W] : quo_q[LOW_W][Q_W-1:0];
      sat_q <= clip;
    end
  end

  assign valid_o = v_q[DIV_LAT-1];
  assign quo_o   = res_q;
  assign sat_o   = sat_q;

endmodule

### rtl/integral_criterion_pi_tuning.sv
// ----------------------------------------------------------------------------
// integral_criterion_pi_tuning
// PI tuning from a first-order-plus-dead-time model by integral criteria.
// ----------------------------------------------------------------------------
// Input stream (s_axis_*): one word per model, fields gain, tau, dead time.
// Output stream (m_axis_*): one word per input word, in order: Kp, Ti, Ki,
// status and saturation flag.
// Config (APB): criterion at 0x0, response kind at 0x4; write only while
// no word is in flight.
// Path: the input word passes the input register, 19-stage log2,
// 17-stage power unit, one product stage, two 36-stage dividers in series
// (Kp and Ti side by side, then Ki) and the output register before
// m_axis_tvalid rises.
// Throughput: one word per cycle while not frozen by a receiver stall; every stage holds at most one word.
// Receiver stall: the output register plus a one-word skid buffer absorb
// the stall; the pipeline freezes while the skid holds a word, and
// s_axis_tready drops for that time. Nothing is lost or repeated.
// Reset: pipeline empties, criterion goes to ISE, response kind to setpoint.
// ----------------------------------------------------------------------------
module integral_criterion_pi_tuning (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // process_gain, time_constant, dead_time
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // prop_gain, integral_time,
                                       // integral_gain, result_status, saturated
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import icpt_pkg::*;

  localparam int SL1_LEN = LOG_LAT + EXP_LAT;

  logic        en;
  logic [1:0]  crit_q;
  logic        kind_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crit_q <= CRIT_ISE;
      kind_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_CRIT: crit_q <= pwdata[1:0];
        REG_KIND: kind_q <= pwdata[0];
        default:  ;
      endcase
    end
  end

  assign pready = 1'b1;
  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_CRIT: prdata = {30'b0, crit_q};
      REG_KIND: prdata = {31'b0, kind_q};
      default:  prdata = '0;
    endcase
  end

  // input stage
  logic [31:0] kraw, tau_in, dead_in;
  assign kraw    = s_axis_tdata[31:0];
  assign tau_in  = s_axis_tdata[63:32];
  assign dead_in = s_axis_tdata[95:64];

  side_in_t side_d;
  always_comb begin
    side_d.neg    = kraw[31];
    side_d.kmag   = kraw[31] ? ({1'b0, ~kraw} + 33'd1) : {1'b0, kraw};
    side_d.cap    = kraw[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    side_d.tau    = tau_in;
    side_d.coef   = coef_lookup(kind_q, crit_q);
    if (kraw == '0 || tau_in == '0) begin
      side_d.status = ST_ZERO_IN;
    end else if (dead_in == '0) begin
      side_d.status = ST_ZERO_DEAD;
    end else begin
      side_d.status = ST_OK;
    end
  end

  logic        in_v_q;
  side_in_t    in_side_q;
  logic [31:0] in_tau_q, in_dead_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (en) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_side_q <= side_d;
      in_tau_q  <= tau_in;
      in_dead_q <= dead_in;
    end
  end

  side_in_t sl1 [SL1_LEN];
  always_ff @(posedge clk_i) begin
    if (en) begin
      sl1[0] <= in_side_q;
      for (int i = 1; i < SL1_LEN; i++) sl1[i] <= sl1[i-1];
    end
  end

  // log2 and power units
  logic               lg_v;
  logic signed [21:0] lg;

  icpt_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_v_q),
    .tau_i   (in_tau_q),
    .dead_i  (in_dead_q),
    .valid_o (lg_v),
    .lg_o    (lg)
  );

  logic               ex_v;
  logic [30:0]        mant_kp, mant_ti;
  logic signed [8:0]  exp_kp, exp_ti;

  icpt_exp2 u_exp2 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (lg_v),
    .lg_i      (lg),
    .coef_b_i  (sl1[LOG_LAT-1].coef.b),
    .coef_d_i  (sl1[LOG_LAT-1].coef.d),
    .valid_o   (ex_v),
    .mant_kp_o (mant_kp),
    .exp_kp_o  (exp_kp),
    .mant_ti_o (mant_ti),
    .exp_ti_o  (exp_ti)
  );

  // operand forming stage
  side_in_t sx;
  assign sx = sl1[SL1_LEN-1];

  logic                   fm_v_q;
  logic [NUM_W-1:0]       kp_num_q, kp_den_q, ti_num_q, ti_den_q;
  logic signed [SH_W-1:0] kp_sh_q, ti_sh_q;
  side_div_t              fm_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fm_v_q <= 1'b0;
    end else if (en) begin
      fm_v_q <= ex_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kp_num_q  <= NUM_W'(48'(sx.coef.a[16:0]) * 48'(mant_kp));
      kp_sh_q   <= $signed({exp_kp[8], exp_kp}) + SH_W'(KP_SHIFT_OFS);
      kp_den_q  <= NUM_W'(sx.kmag);
      ti_num_q  <= NUM_W'(sx.tau);
      ti_sh_q   <= SH_W'(TI_SHIFT_OFS) - $signed({exp_ti[8], exp_ti});
      ti_den_q  <= NUM_W'(48'(sx.coef.c[16:0]) * 48'(mant_ti));
      fm_side_q <= '{status: sx.status, neg: sx.neg, cap: sx.cap};
    end
  end

  side_div_t sl2 [DIV_LAT];
  always_ff @(posedge clk_i) begin
    if (en) begin
      sl2[0] <= fm_side_q;
      for (int i = 1; i < DIV_LAT; i++) sl2[i] <= sl2[i-1];
    end
  end

  logic            kp_v, ti_v, kp_sat, ti_sat;
  logic [Q_W-1:0]  kp_q, ti_q;

  icpt_div u_div_kp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fm_v_q),
    .num_i   (kp_num_q),
    .shift_i (kp_sh_q),
    .den_i   (kp_den_q),
    .cap_i   (fm_side_q.cap),
    .valid_o (kp_v),
    .quo_o   (kp_q),
    .sat_o   (kp_sat)
  );

  icpt_div u_div_ti (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fm_v_q),
    .num_i   (ti_num_q),
    .shift_i (ti_sh_q),
    .den_i   (ti_den_q),
    .cap_i   (32'hFFFF_FFFF),
    .valid_o (ti_v),
    .quo_o   (ti_q),
    .sat_o   (ti_sat)
  );

  // Ki from clipped Kp and Ti
  side_div_t sd;
  side_ki_t  ki_side;
  assign sd = sl2[DIV_LAT-1];
  always_comb begin
    ki_side.status = sd.status;
    ki_side.neg    = sd.neg;
    ki_side.cap    = sd.cap;
    ki_side.kp     = kp_q;
    ki_side.ti     = ti_q;
    ki_side.sat    = kp_sat | ti_sat;
  end

  side_ki_t sl3 [DIV_LAT];
  always_ff @(posedge clk_i) begin
    if (en) begin
      sl3[0] <= ki_side;
      for (int i = 1; i < DIV_LAT; i++) sl3[i] <= sl3[i-1];
    end
  end

  logic           ki_v, ki_sat;
  logic [Q_W-1:0] ki_q;

  icpt_div u_div_ki (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (kp_v & ti_v),
    .num_i   (NUM_W'(kp_q)),
    .shift_i (SH_W'(FRAC_BITS)),
    .den_i   (NUM_W'(ti_q)),
    .cap_i   (sd.cap),
    .valid_o (ki_v),
    .quo_o   (ki_q),
    .sat_o   (ki_sat)
  );

  // result assembly
  side_ki_t    sk;
  result_t     fin;
  logic [31:0] ki_mag;
  logic        sat_all;
  assign sk = sl3[DIV_LAT-1];

  always_comb begin
    if (sk.ti == '0) begin
      ki_mag  = (sk.kp != '0) ? sk.cap : '0;
      sat_all = sk.sat | (sk.kp != '0);
    end else begin
      ki_mag  = ki_q;
      sat_all = sk.sat | ki_sat;
    end
    if (sk.status != ST_OK) begin
      fin = '0;
      fin.result_status = sk.status;
    end else begin
      fin.prop_gain     = sk.neg ? 32'(-sk.kp) : sk.kp;
      fin.integral_time = sk.ti;
      fin.integral_gain = sk.neg ? 32'(-ki_mag) : ki_mag;
      fin.result_status = ST_OK;
      fin.saturated     = sat_all;
    end
  end

  // output register with skid
  logic    out_v_q, skid_v_q;
  result_t out_q, skid_q;

  assign en = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_v_q && !m_axis_tready) begin
      if (en && ki_v) skid_v_q <= 1'b1;
    end else if (skid_v_q) begin
      out_v_q  <= 1'b1;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= ki_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_v_q && !m_axis_tready) begin
      if (en && ki_v) skid_q <= fin;
    end else if (skid_v_q) begin
      out_q <= skid_q;
    end else begin
      out_q <= fin;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'b0, out_q};

endmodule

### rtl/icpt_checker.sv
// ----------------------------------------------------------------------------
// icpt_checker
// Port-level checks for the PI tuner, bound to the top level.
// ----------------------------------------------------------------------------
module icpt_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata
);
  import icpt_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_special_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[97:96] != ST_OK) |->
      (m_axis_tdata[95:0] == '0) && !m_axis_tdata[98])
    else $error("special case word carries values");

  a_ti_zero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[97:96] == ST_OK) && (m_axis_tdata[63:32] == '0)
      && (m_axis_tdata[31:0] != '0) |-> m_axis_tdata[98])
    else $error("zero Ti with nonzero Kp not flagged");

endmodule

bind integral_criterion_pi_tuning icpt_checker u_icpt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
